>>> src/slcp_pkg.sv
`default_nettype none

package slcp_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned SKIP_W      = 5;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD_LENGTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTENTION_THRESHOLD = 4'd1;

   localparam logic [BYTE_W-1:0] MAX_PAYLOAD_LENGTH_RESET  = 8'd169;
   localparam logic [BYTE_W-1:0] ATTENTION_THRESHOLD_RESET = 8'd60;

   localparam logic [BYTE_W-1:0] SYNC_BYTE      = 8'hAA;
   localparam logic [BYTE_W-1:0] QUALITY_ABSENT = 8'd200;

   // Payload code bytes.
   localparam logic [BYTE_W-1:0] CODE_QUALITY   = 8'h02;
   localparam logic [BYTE_W-1:0] CODE_ATTENTION = 8'h04;
   localparam logic [BYTE_W-1:0] CODE_SKIP1_A   = 8'h05;
   localparam logic [BYTE_W-1:0] CODE_SKIP1_B   = 8'h16;
   localparam logic [BYTE_W-1:0] CODE_SKIP3     = 8'h80;
   localparam logic [BYTE_W-1:0] CODE_SKIP25    = 8'h83;

   localparam logic [SKIP_W-1:0] SKIP_ONE         = 5'd1;
   localparam logic [SKIP_W-1:0] SKIP_THREE       = 5'd3;
   localparam logic [SKIP_W-1:0] SKIP_TWENTY_FIVE = 5'd25;

   typedef struct packed {
      logic [BYTE_W-1:0] attention_level;
      logic [BYTE_W-1:0] signal_quality;
      logic              quality_present;
      logic              led_on;
      logic              trigger_fire;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> src/slcp_ifs.sv
`default_nettype none

interface slcp_req_if;
   import slcp_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface slcp_rsp_if;
   import slcp_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] attention_level;
   logic [BYTE_W-1:0] signal_quality;
   logic              quality_present;
   logic              led_on;
   logic              trigger_fire;
   modport source (output valid, output attention_level, output signal_quality,
                   output quality_present, output led_on, output trigger_fire,
                   input ready);
   modport sink (input valid, input attention_level, input signal_quality,
                 input quality_present, input led_on, input trigger_fire,
                 output ready);
endinterface

interface slcp_csr_if;
   import slcp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [BYTE_W-1:0]      wr_data;
   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

>>> src/sync_length_checksum_packet_parser.sv
`default_nettype none

// Byte-serial frame parser. Each item on req_ch is one received byte. The
// parser hunts for two sync bytes 0xAA, takes a length byte (frames longer
// than max_payload_length are dropped), streams the payload through an
// 8-bit sum and a code decoder, and checks the final byte against 255 minus
// the sum. A frame with a good checksum yields one item on rsp_ch with the
// decoded attention, quality, quality-present flag, LED state and the
// one-time trigger; other bytes yield nothing.
// Throughput is one byte per cycle outside stalls: every byte updates the
// parser state registers in the cycle it is accepted. A frame's result is
// registered into the rsp_ch output register when its checksum byte is taken.
// When the receiver stalls, the held result does not block the input; bytes
// keep flowing until the parser reaches the checksum byte of the next
// frame, which waits until the held result is taken.
// csr_ch is always ready; register 0 is max_payload_length (reset 169),
// register 1 is attention_threshold (reset 60). Writes to other indexes are
// ignored. Reset returns the parser to hunting for the first sync byte,
// clears the LED state and the trigger, and empties the output register.
module sync_length_checksum_packet_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   slcp_req_if.sink   req_ch,
   slcp_rsp_if.source rsp_ch,
   slcp_csr_if.sink   csr_ch
);
   import slcp_pkg::*;

   typedef enum logic [2:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_LEN,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   typedef enum logic [1:0] {
      VK_CODE,
      VK_QUALITY,
      VK_ATTENTION,
      VK_SKIP
   } value_kind_type;

   logic [BYTE_W-1:0] max_len_ff;
   logic [BYTE_W-1:0] attn_thr_ff;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [SKIP_W-1:0] skip_left_ff, skip_left_in;
   value_kind_type    kind_ff, kind_in;
   logic [BYTE_W-1:0] quality_ff, quality_in;
   logic [BYTE_W-1:0] attention_ff, attention_in;
   logic              seen_ff, seen_in;
   logic              led_ff, led_in;
   logic              done_ff, done_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff;
   rsp_payload_type   rsp_new;

   logic              req_fire;
   logic              frame_good;
   logic              fire;
   logic [BYTE_W-1:0] b;

   // Only the checksum byte can produce a result, so it alone waits for a
   // free output register.
   assign req_ch.ready = !(phase_ff == PH_CHECK) || !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign b            = req_ch.data_byte;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      sum_in        = sum_ff;
      skip_left_in  = skip_left_ff;
      kind_in       = kind_ff;
      quality_in    = quality_ff;
      attention_in  = attention_ff;
      seen_in       = seen_ff;
      led_in        = led_ff;
      done_in       = done_ff;
      frame_good    = 1'b0;
      fire          = 1'b0;
      if (req_fire) begin
         unique case (phase_ff)
            PH_SYNC1: begin
               if (b == SYNC_BYTE) phase_in = PH_SYNC2;
            end
            PH_SYNC2: begin
               phase_in = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
            end
            PH_LEN: begin
               if (b > max_len_ff) begin
                  phase_in = PH_SYNC1;
               end else begin
                  bytes_left_in = b;
                  sum_in        = '0;
                  skip_left_in  = '0;
                  kind_in       = VK_CODE;
                  quality_in    = QUALITY_ABSENT;
                  attention_in  = '0;
                  seen_in       = 1'b0;
                  phase_in      = (b == '0) ? PH_CHECK : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               sum_in        = sum_ff + b;
               bytes_left_in = bytes_left_ff - 1'b1;
               if (bytes_left_ff == BYTE_W'(1)) phase_in = PH_CHECK;
               unique case (kind_ff)
                  VK_QUALITY: begin
                     quality_in = b;
                     kind_in    = VK_CODE;
                  end
                  VK_ATTENTION: begin
                     attention_in = b;
                     kind_in      = VK_CODE;
                  end
                  VK_SKIP: begin
                     skip_left_in = skip_left_ff - 1'b1;
                     if (skip_left_ff == SKIP_W'(1)) kind_in = VK_CODE;
                  end
                  VK_CODE: begin
                     priority if (b == CODE_QUALITY) begin
                        seen_in = 1'b1;
                        kind_in = VK_QUALITY;
                     end else if (b == CODE_ATTENTION) begin
                        kind_in = VK_ATTENTION;
                     end else if (b == CODE_SKIP1_A || b == CODE_SKIP1_B) begin
                        skip_left_in = SKIP_ONE;
                        kind_in      = VK_SKIP;
                     end else if (b == CODE_SKIP3) begin
                        skip_left_in = SKIP_THREE;
                        kind_in      = VK_SKIP;
                     end else if (b == CODE_SKIP25) begin
                        skip_left_in = SKIP_TWENTY_FIVE;
                        kind_in      = VK_SKIP;
                     end else begin
                        kind_in = VK_CODE;
                     end
                  end
                  default: kind_in = VK_CODE;
               endcase
            end
            PH_CHECK: begin
               phase_in = PH_SYNC1;
               // 255 minus the sum is the bitwise complement in eight bits.
               if (b == ~sum_ff) begin
                  frame_good = 1'b1;
                  if (seen_ff) begin
                     led_in = (quality_ff == '0);
                     if (attention_ff > attn_thr_ff && !done_ff) begin
                        done_in = 1'b1;
                        fire    = 1'b1;
                     end
                  end
               end
            end
            default: phase_in = PH_SYNC1;
         endcase
      end
   end

   always_comb begin
      rsp_new.attention_level = attention_ff;
      rsp_new.signal_quality  = quality_ff;
      rsp_new.quality_present = seen_ff;
      rsp_new.led_on          = led_in;
      rsp_new.trigger_fire    = fire;
   end

   assign rsp_valid_in = frame_good || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= MAX_PAYLOAD_LENGTH_RESET;
         attn_thr_ff   <= ATTENTION_THRESHOLD_RESET;
         phase_ff      <= PH_SYNC1;
         bytes_left_ff <= '0;
         sum_ff        <= '0;
         skip_left_ff  <= '0;
         kind_ff       <= VK_CODE;
         quality_ff    <= QUALITY_ABSENT;
         attention_ff  <= '0;
         seen_ff       <= 1'b0;
         led_ff        <= 1'b0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            if (csr_ch.reg_index == CSR_MAX_PAYLOAD_LENGTH) max_len_ff <= csr_ch.wr_data;
            if (csr_ch.reg_index == CSR_ATTENTION_THRESHOLD) attn_thr_ff <= csr_ch.wr_data;
         end
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         sum_ff        <= sum_in;
         skip_left_ff  <= skip_left_in;
         kind_ff       <= kind_in;
         quality_ff    <= quality_in;
         attention_ff  <= attention_in;
         seen_ff       <= seen_in;
         led_ff        <= led_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_good) rsp_ff <= rsp_new;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.attention_level = rsp_ff.attention_level;
   assign rsp_ch.signal_quality  = rsp_ff.signal_quality;
   assign rsp_ch.quality_present = rsp_ff.quality_present;
   assign rsp_ch.led_on          = rsp_ff.led_on;
   assign rsp_ch.trigger_fire    = rsp_ff.trigger_fire;

`ifndef SYNTHESIS
   // A new result never overwrites one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      frame_good |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("result overwrote a pending item");

   // Once the trigger has fired it never fires again.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !fire)
      else $error("trigger fired twice");

   // The payload phase always has at least one byte still to come.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (bytes_left_ff != '0))
      else $error("payload phase with no bytes left");

   // Quality stays at its absent value until a quality code is seen.
   assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> (quality_ff == QUALITY_ABSENT))
      else $error("quality changed without a quality code");

   // Input stalls only at a checksum byte behind a held result.
   assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (phase_ff == PH_CHECK && rsp_valid_ff))
      else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire
